### src/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared constants and tables for the haversine distance core
// Fixed-point formats, divider reciprocals, CORDIC arctangent table and
// the distance scale factor.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int CORDIC_STAGES   = 24;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 23;

  localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [LAT_W-1:0] LAT_NEG = -LAT_LIM;
  localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [LON_W-1:0] LON_NEG = -LON_LIM;

  localparam int MAG_W = 25;
  localparam int ANG_W = 31;

  localparam int TURN_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int HALF_SH    = TURN_SHIFT - 4;
  localparam int FULL_SH    = TURN_SHIFT - 3;
  localparam int HALF_ADD   = 360 / 16;
  localparam int FULL_ADD   = 180 / 8;
  localparam int DIV_K      = 45;
  localparam int DIV_SHIFT  = 32;
  localparam int DIVM_W     = 27;
  localparam logic [DIVM_W-1:0] DIV_M = DIVM_W'((64'd1 << DIV_SHIFT) / DIV_K);
  localparam int REM_W = 6;
  localparam int P1_W  = MAG_W + DIVM_W;
  localparam int Q_W   = P1_W - DIV_SHIFT;
  localparam int W_W   = REM_W + FULL_SH;
  localparam int P2_W  = W_W + DIVM_W;
  localparam int QB_W  = P2_W - DIV_SHIFT;
  localparam int T_W   = Q_W + FULL_SH;

  localparam int XY_W  = 34;
  localparam int Z_W   = 34;
  localparam int IDX_W = 5;

  localparam int Q30_W = 31;
  localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(1) << 30;
  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(32'h26DD3B6A);
  localparam int PROD_W = 2 * Q30_W;

  localparam int SQ_W     = 62;
  localparam int SQ_STEPS = 31;

  localparam longint unsigned DIST_SCALE =
    (64'd6371 * 64'hC90FDAA2 + 64'd2048) >> 12;
  localparam int SLO_W = 16;
  localparam int SHI_W = 17;
  localparam logic [SHI_W-1:0] SCALE_HI = SHI_W'(DIST_SCALE >> SLO_W);
  localparam logic [SLO_W-1:0] SCALE_LO = SLO_W'(DIST_SCALE);
  localparam int DSUM_W = 64;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int LATENCY = 2 + 5 + CORDIC_STAGES + 5 + SQ_STEPS + CORDIC_STAGES + 3;

  function automatic logic [Z_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return Z_W'(v);
  endfunction

endpackage

### src/hvd_turns.sv
// ----------------------------------------------------------------------------
// hvd_turns: degree magnitude to turn angle
// Converts a fixed-point degree magnitude, halved if half is set, to 2^-32
// turn, rounded, by two reciprocal divisions by 45; folds about 90 degrees.
// ----------------------------------------------------------------------------
module hvd_turns import hvd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic             half,
  input  logic [MAG_W-1:0] mag,
  output logic [ANG_W-1:0] ang
);

  logic [P1_W-1:0]  p1;
  logic [MAG_W-1:0] mag1;
  logic [Q_W-1:0]   q2;
  logic [REM_W-1:0] r2;
  logic [P2_W-1:0]  p3;
  logic [Q_W-1:0]   q3;
  logic [W_W-1:0]   w3;
  logic [T_W-1:0]   t4;

  logic [Q_W-1:0]   q0;
  logic [MAG_W-1:0] r0;
  logic [Q_W-1:0]   q_next;
  logic [REM_W-1:0] r_next;
  logic [W_W-1:0]   w_next;
  logic [QB_W-1:0]  qb0;
  logic [W_W-1:0]   rb;
  logic [QB_W-1:0]  qb;
  logic [T_W-1:0]   t_next;

  always_comb begin
    q0 = p1[P1_W-1:DIV_SHIFT];
    r0 = mag1 - MAG_W'(q0 * DIV_K);
    if (r0 >= MAG_W'(DIV_K)) begin
      q_next = q0 + Q_W'(1);
      r_next = REM_W'(r0 - MAG_W'(DIV_K));
    end else begin
      q_next = q0;
      r_next = REM_W'(r0);
    end
    if (half) begin
      w_next = (W_W'(r2) << HALF_SH) + W_W'(HALF_ADD);
    end else begin
      w_next = (W_W'(r2) << FULL_SH) + W_W'(FULL_ADD);
    end
    qb0 = p3[P2_W-1:DIV_SHIFT];
    rb  = w3 - W_W'(qb0 * DIV_K);
    qb  = (rb >= W_W'(DIV_K)) ? qb0 + QB_W'(1) : qb0;
    if (half) begin
      t_next = (T_W'(q3) << HALF_SH) + T_W'(qb);
    end else begin
      t_next = (T_W'(q3) << FULL_SH) + T_W'(qb);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= P1_W'(mag) * P1_W'(DIV_M);
      mag1 <= mag;
      q2   <= q_next;
      r2   <= r_next;
      p3   <= P2_W'(w_next) * P2_W'(DIV_M);
      q3   <= q2;
      w3   <= w_next;
      t4   <= t_next;
      if (t4 > (T_W'(1) << 30)) begin
        ang <= ANG_W'((T_W'(1) << 31) - t4);
      end else begin
        ang <= ANG_W'(t4);
      end
    end
  end

endmodule

### src/hvd_cordic_cell.sv
// ----------------------------------------------------------------------------
// hvd_cordic_cell: one CORDIC micro-rotation
// Rotation or vectoring step with a fixed shift index, registered output.
// ----------------------------------------------------------------------------
module hvd_cordic_cell import hvd_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   vec,
  input  logic [IDX_W-1:0]       idx,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  output logic signed [XY_W-1:0] x_out,
  output logic signed [XY_W-1:0] y_out,
  output logic signed [Z_W-1:0]  z_out
);

  logic signed [XY_W-1:0] dx, dy, x_next, y_next;
  logic signed [Z_W-1:0]  da, z_next;
  logic                   up;

  always_comb begin
    dx = y_in >>> idx;
    dy = x_in >>> idx;
    da = signed'(atan_turn(idx));
    up = vec ? y_in[XY_W-1] : !z_in[Z_W-1];
    if (up) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - da;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

### src/hvd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// hvd_sqrt_cell: one digit of a floor square root
// Trial subtract of one bit pair, registered remainder and root.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell import hvd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] k,
  input  logic [SQ_W-1:0]  v_in,
  input  logic [SQ_W-1:0]  r_in,
  output logic [SQ_W-1:0]  v_out,
  output logic [SQ_W-1:0]  r_out
);

  logic [SQ_W-1:0] b, rb, v_next, r_next;

  always_comb begin
    b  = SQ_W'(1) << {k, 1'b0};
    rb = r_in + b;
    if (v_in >= rb) begin
      v_next = v_in - rb;
      r_next = (r_in >> 1) + b;
    end else begin
      v_next = v_in;
      r_next = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
      r_out <= r_next;
    end
  end

endmodule

### src/haversine_distance_core.sv
// ----------------------------------------------------------------------------
// haversine_distance_core: great-circle distance between two points
// Streams coordinate pairs through a fully pipelined haversine datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): lat_a, lon_a, lat_b, lon_b in 2^-16
// degree, clamped to +-90 and +-180 degrees.
// Output channel (out_valid/out_ready): distance in 2^-8 km on a 6371 km
// sphere.
// Throughput: one beat per cycle when not stalled. The datapath is a chain of
// registered cells: degree conversion, four sine/cosine CORDIC rows, the
// products, two square-root rows and one arctangent CORDIC row.
// A beat passes through 94 pipeline stages and then the output register.
// Stall: the output register holds while it has a beat and out_ready is low;
// one more beat lands in a skid register, then in_ready drops and the pipeline freezes.
// in_ready is a register and does not depend on out_ready combinationally.
// Reset: clears all valid bits, also those of the output and skid registers
// (not their data); in_ready is high from the first cycle after reset.
// ----------------------------------------------------------------------------
module haversine_distance_core import hvd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] lat_a,
  input  logic signed [LON_W-1:0] lon_a,
  input  logic signed [LAT_W-1:0] lat_b,
  input  logic signed [LON_W-1:0] lon_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       distance
);

  function automatic logic [Q30_W-1:0] clamp_q30(input logic signed [XY_W-1:0] v);
    logic [Q30_W-1:0] r;
    if (v[XY_W-1]) begin
      r = '0;
    end else if (v > signed'(XY_W'(ONE_Q30))) begin
      r = ONE_Q30;
    end else begin
      r = Q30_W'(v);
    end
    return r;
  endfunction

  logic                   en;
  logic [LATENCY-1:0]     vld;
  logic                   skid_v;
  logic [DIST_W-1:0]      skid_d;
  logic [DIST_W-1:0]      dist_p;

  logic signed [LAT_W-1:0] la1, lb1;
  logic signed [LON_W-1:0] oa1, ob1;
  logic signed [LAT_W-1:0] la_next, lb_next;
  logic signed [LON_W-1:0] oa_next, ob_next;
  logic signed [LON_W-1:0] dlat;
  logic signed [LON_W:0]   dlon;
  logic [MAG_W-1:0]        mag [4];
  logic [ANG_W-1:0]        ang [4];
  logic                    half_sel [4];

  logic signed [XY_W-1:0] rx [4][CORDIC_STAGES+1];
  logic signed [XY_W-1:0] ry [4][CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  rz [4][CORDIC_STAGES+1];

  logic [Q30_W-1:0]  s_lat, s_lon, c_a, c_b;
  logic [PROD_W-1:0] pr_lat, pr_lon, pr_cc, pr_x;
  logic [Q30_W-1:0]  sl2, sn2, cc, sl2_d;
  logic [Q30_W:0]    a_sum;
  logic [Q30_W-1:0]  a_q;

  logic [SQ_W-1:0] sqv [2][SQ_STEPS+1];
  logic [SQ_W-1:0] sqr [2][SQ_STEPS+1];

  logic signed [XY_W-1:0] vx [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] vy [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  vz [CORDIC_STAGES+1];

  logic [Q30_W-1:0]         zc;
  logic [Q30_W+SHI_W-1:0]   p_hi;
  logic [Q30_W+SLO_W-1:0]   p_lo;
  logic [DSUM_W-1:0]        dsum;
  logic [DSUM_W-1:0]        dq;

  assign en       = !skid_v;
  assign in_ready = !skid_v;

  always_comb begin
    la_next = lat_a;
    if (lat_a > LAT_LIM) la_next = LAT_LIM;
    else if (lat_a < LAT_NEG) la_next = LAT_NEG;
    lb_next = lat_b;
    if (lat_b > LAT_LIM) lb_next = LAT_LIM;
    else if (lat_b < LAT_NEG) lb_next = LAT_NEG;
    oa_next = lon_a;
    if (lon_a > LON_LIM) oa_next = LON_LIM;
    else if (lon_a < LON_NEG) oa_next = LON_NEG;
    ob_next = lon_b;
    if (lon_b > LON_LIM) ob_next = LON_LIM;
    else if (lon_b < LON_NEG) ob_next = LON_NEG;
    dlat = LON_W'(lb1) - LON_W'(la1);
    dlon = (LON_W+1)'(ob1) - (LON_W+1)'(oa1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la1 <= la_next;
      lb1 <= lb_next;
      oa1 <= oa_next;
      ob1 <= ob_next;
      mag[0] <= dlat[LON_W-1] ? MAG_W'(-dlat) : MAG_W'(dlat);
      mag[1] <= dlon[LON_W] ? MAG_W'(-dlon) : MAG_W'(dlon);
      mag[2] <= la1[LAT_W-1] ? MAG_W'(-la1) : MAG_W'(la1);
      mag[3] <= lb1[LAT_W-1] ? MAG_W'(-lb1) : MAG_W'(lb1);
    end
  end

  assign half_sel[0] = 1'b1;
  assign half_sel[1] = 1'b1;
  assign half_sel[2] = 1'b0;
  assign half_sel[3] = 1'b0;

  for (genvar c = 0; c < 4; c++) begin : g_rot
    hvd_turns u_turns (
      .clk  (clk),
      .en   (en),
      .half (half_sel[c]),
      .mag  (mag[c]),
      .ang  (ang[c])
    );
    assign rx[c][0] = INV_GAIN;
    assign ry[c][0] = '0;
    assign rz[c][0] = signed'(Z_W'(ang[c]));
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      hvd_cordic_cell u_cell (
        .clk   (clk),
        .en    (en),
        .vec   (1'b0),
        .idx   (IDX_W'(i)),
        .x_in  (rx[c][i]),
        .y_in  (ry[c][i]),
        .z_in  (rz[c][i]),
        .x_out (rx[c][i+1]),
        .y_out (ry[c][i+1]),
        .z_out (rz[c][i+1])
      );
    end
  end

  always_comb begin
    a_sum = (Q30_W+1)'(sl2_d) + (Q30_W+1)'((pr_x + (PROD_W'(1) << 29)) >> 30);
    a_q   = (a_sum > (Q30_W+1)'(ONE_Q30)) ? ONE_Q30 : Q30_W'(a_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_lat  <= clamp_q30(ry[0][CORDIC_STAGES]);
      s_lon  <= clamp_q30(ry[1][CORDIC_STAGES]);
      c_a    <= clamp_q30(rx[2][CORDIC_STAGES]);
      c_b    <= clamp_q30(rx[3][CORDIC_STAGES]);
      pr_lat <= PROD_W'(s_lat) * PROD_W'(s_lat);
      pr_lon <= PROD_W'(s_lon) * PROD_W'(s_lon);
      pr_cc  <= PROD_W'(c_a) * PROD_W'(c_b);
      sl2    <= Q30_W'((pr_lat + (PROD_W'(1) << 29)) >> 30);
      sn2    <= Q30_W'((pr_lon + (PROD_W'(1) << 29)) >> 30);
      cc     <= Q30_W'((pr_cc + (PROD_W'(1) << 29)) >> 30);
      pr_x   <= PROD_W'(cc) * PROD_W'(sn2);
      sl2_d  <= sl2;
      sqv[0][0] <= SQ_W'(a_q) << 30;
      sqv[1][0] <= SQ_W'(ONE_Q30 - a_q) << 30;
    end
  end

  for (genvar s = 0; s < 2; s++) begin : g_sqrt
    assign sqr[s][0] = '0;
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      hvd_sqrt_cell u_cell (
        .clk   (clk),
        .en    (en),
        .k     (IDX_W'(SQ_STEPS - 1 - j)),
        .v_in  (sqv[s][j]),
        .r_in  (sqr[s][j]),
        .v_out (sqv[s][j+1]),
        .r_out (sqr[s][j+1])
      );
    end
  end

  assign vx[0] = signed'(XY_W'(sqr[1][SQ_STEPS][Q30_W-1:0]));
  assign vy[0] = signed'(XY_W'(sqr[0][SQ_STEPS][Q30_W-1:0]));
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    hvd_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .vec   (1'b1),
      .idx   (IDX_W'(i)),
      .x_in  (vx[i]),
      .y_in  (vy[i]),
      .z_in  (vz[i]),
      .x_out (vx[i+1]),
      .y_out (vy[i+1]),
      .z_out (vz[i+1])
    );
  end

  always_comb begin
    dsum = (DSUM_W'(p_hi) << SLO_W) + DSUM_W'(p_lo)
         + (DSUM_W'(1) << (47 - DIST_FRAC_BITS));
    dq   = dsum >> (48 - DIST_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc     <= clamp_q30(vz[CORDIC_STAGES]);
      p_hi   <= (Q30_W+SHI_W)'(zc) * (Q30_W+SHI_W)'(SCALE_HI);
      p_lo   <= (Q30_W+SLO_W)'(zc) * (Q30_W+SLO_W)'(SCALE_LO);
      dist_p <= (dq > DSUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[LATENCY-2:0], in_valid};
        if (out_valid && !out_ready) begin
          if (vld[LATENCY-1]) skid_v <= 1'b1;
        end else begin
          out_valid <= vld[LATENCY-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid && !out_ready) begin
        skid_d <= dist_p;
      end else begin
        distance <= dist_p;
      end
    end else if (out_ready) begin
      distance <= skid_d;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid beat held without an output beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input blocked without an output stall");

  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat lost at pipeline entry");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LATENCY-1] && !(out_valid && !out_ready)) |=> out_valid)
    else $error("finished beat not moved to output");

endmodule
